// File: rtl/otb_pkg.sv
// otb_pkg: shared types and constants for the one-shot timer bank.
// Request kinds, queue opcodes, state codes and the front-to-back queue entry.
// No dependencies.
`timescale 1ns / 1ps

package otb_pkg;

   localparam int KIND_W   = 3;
   localparam int ID_W     = 4;
   localparam int PERIOD_W = 16;
   localparam int CODE_W   = 2;

   localparam int TIMERS_DEFAULT     = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 3'd0,
      KIND_CREATE  = 3'd1,
      KIND_RESTART = 3'd2,
      KIND_DELETE  = 3'd3,
      KIND_SET_RUN = 3'd4,
      KIND_QUERY   = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_CREATE,
      OP_RESTART,
      OP_DELETE,
      OP_SET_RUN,
      OP_QUERY
   } op_type;

   localparam logic [CODE_W-1:0] CODE_STOPPED = 2'd0;
   localparam logic [CODE_W-1:0] CODE_RUNNING = 2'd1;
   localparam logic [CODE_W-1:0] CODE_UNARMED = 2'd2;

   typedef struct packed {
      op_type                op;
      logic [ID_W-1:0]       id;
      logic                  in_range;
      logic                  handler;
      logic [PERIOD_W-1:0]   period;
      logic                  run;
   } queue_item_type;

endpackage

// File: rtl/otb_front.sv
// otb_front: accepts requests, decodes the kind, drops unused kinds and
// queues the rest in a two-entry queue for the back end. Uses otb_pkg.
`timescale 1ns / 1ps

module otb_front
   import otb_pkg::*;
#(
   parameter int TIMERS = TIMERS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [ID_W-1:0]       req_timer_id,
   input  logic                  req_with_handler,
   input  logic [PERIOD_W-1:0]   req_period_ticks,
   input  logic                  req_run_request,
   output logic                  q_valid,
   output queue_item_type        q_item,
   input  logic                  q_pop
);

   queue_item_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;

   queue_item_type dec;
   logic           keep;
   logic           push;

   always_comb begin
      keep          = 1'b1;
      dec.op        = OP_TICK;
      dec.id        = req_timer_id;
      dec.in_range  = (32'(req_timer_id) < TIMERS);
      dec.handler   = req_with_handler;
      dec.period    = req_period_ticks;
      dec.run       = req_run_request;
      case (kind_type'(req_kind))
         KIND_TICK:    dec.op = OP_TICK;
         KIND_CREATE:  dec.op = OP_CREATE;
         KIND_RESTART: dec.op = OP_RESTART;
         KIND_DELETE:  dec.op = OP_DELETE;
         KIND_SET_RUN: dec.op = OP_SET_RUN;
         KIND_QUERY:   dec.op = OP_QUERY;
         default:      keep = 1'b0;
      endcase
   end

   assign busy    = (fill_ff == 2'd2);
   assign push    = start && !busy && keep;
   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// File: rtl/otb_back.sv
// otb_back: executes queued requests against the timer entries.
// Armed and running flags are flip-flops; count and period sit in memories.
// Uses otb_pkg.
`timescale 1ns / 1ps

module otb_back
   import otb_pkg::*;
#(
   parameter int TIMERS     = TIMERS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  queue_item_type      q_item,
   output logic                q_pop,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_entry_index,
   output logic                rsp_expired,
   output logic                rsp_status,
   output logic [CODE_W-1:0]   rsp_state_code,
   output logic                rsp_last
);

   localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TIMERS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [TIMERS-1:0]    armed_ff, armed_in;
   logic [TIMERS-1:0]    running_ff, running_in;
   logic [IDX_W-1:0]     ic_ff, ic_in;
   logic                 issuing_ff, issuing_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic                 pv_ff, pv_in;
   logic                 hold_ff, hold_in;
   logic [IDX_W-1:0]     hold_idx_ff, hold_idx_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [ID_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                 rsp_expired_ff, rsp_expired_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [COUNT_BITS-1:0] cnt_mem [TIMERS];
   logic [PERIOD_W-1:0]   per_mem [TIMERS];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [PERIOD_W-1:0]   per_rd_ff;

   logic                  cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic                  per_we;
   logic [IDX_W-1:0]      per_waddr;
   logic [PERIOD_W-1:0]   per_wdata;

   logic [IDX_W-1:0]      ix;
   logic                  ok;
   logic                  armed_now;
   logic                  running_now;
   logic [COUNT_BITS-1:0] cnt_next;

   always_comb begin
      state_in       = state_ff;
      armed_in       = armed_ff;
      running_in     = running_ff;
      ic_in          = ic_ff;
      issuing_in     = issuing_ff;
      pidx_in        = pidx_ff;
      pv_in          = 1'b0;
      hold_in        = hold_ff;
      hold_idx_in    = hold_idx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_index_in   = rsp_index_ff;
      rsp_expired_in = rsp_expired_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_last_in    = rsp_last_ff;
      q_pop          = 1'b0;
      cnt_we         = 1'b0;
      cnt_waddr      = pidx_ff;
      cnt_wdata      = '0;
      per_we         = 1'b0;
      per_waddr      = '0;
      per_wdata      = q_item.period;
      ix             = IDX_W'(q_item.id);
      ok             = 1'b0;
      armed_now      = 1'b0;
      running_now    = 1'b0;
      cnt_next       = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_TICK) begin
                  ic_in      = '0;
                  issuing_in = 1'b1;
                  hold_in    = 1'b0;
                  state_in   = S_WALK;
               end else begin
                  // out-of-range ids never touch the arrays
                  ok        = q_item.in_range && armed_ff[ix];
                  cnt_waddr = ix;
                  per_waddr = ix;
                  case (q_item.op)
                     OP_CREATE: begin
                        ok = q_item.in_range;
                        if (q_item.in_range) begin
                           armed_in[ix]   = q_item.handler;
                           running_in[ix] = q_item.run;
                           cnt_we         = 1'b1;
                           per_we         = 1'b1;
                        end
                     end
                     OP_RESTART: begin
                        if (ok) begin
                           running_in[ix] = q_item.run;
                           cnt_we         = 1'b1;
                        end
                     end
                     OP_DELETE: begin
                        if (ok) begin
                           armed_in[ix]   = 1'b0;
                           running_in[ix] = 1'b0;
                           cnt_we         = 1'b1;
                        end
                     end
                     OP_SET_RUN: begin
                        if (ok) begin
                           running_in[ix] = q_item.run;
                        end
                     end
                     default: begin
                     end
                  endcase
                  armed_now      = q_item.in_range && armed_in[ix];
                  running_now    = running_in[ix];
                  rsp_strobe_in  = 1'b1;
                  rsp_index_in   = q_item.id;
                  rsp_expired_in = 1'b0;
                  rsp_status_in  = !ok;
                  rsp_code_in    = !armed_now  ? CODE_UNARMED :
                                   running_now ? CODE_RUNNING : CODE_STOPPED;
                  rsp_last_in    = 1'b1;
               end
            end
         end
         S_WALK: begin
            // issue stage reads entry ic; process stage updates entry pidx
            if (issuing_ff) begin
               pv_in   = 1'b1;
               pidx_in = ic_ff;
               if (ic_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  ic_in = ic_ff + 1'b1;
               end
            end
            if (pv_ff && armed_ff[pidx_ff] && running_ff[pidx_ff]) begin
               cnt_we    = 1'b1;
               cnt_wdata = cnt_next;
               if (CMP_W'(cnt_next) >= CMP_W'(per_rd_ff)) begin
                  running_in[pidx_ff] = 1'b0;
                  // an expiry is held one step so the final one can carry last
                  if (hold_ff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_index_in   = ID_W'(hold_idx_ff);
                     rsp_expired_in = 1'b1;
                     rsp_status_in  = 1'b0;
                     rsp_code_in    = CODE_STOPPED;
                     rsp_last_in    = 1'b0;
                  end
                  hold_in     = 1'b1;
                  hold_idx_in = pidx_ff;
               end
            end
            if (pv_ff && !issuing_ff) begin
               state_in = hold_in ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            rsp_strobe_in  = 1'b1;
            rsp_index_in   = ID_W'(hold_idx_ff);
            rsp_expired_in = 1'b1;
            rsp_status_in  = 1'b0;
            rsp_code_in    = CODE_STOPPED;
            rsp_last_in    = 1'b1;
            hold_in        = 1'b0;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         armed_ff      <= '0;
         running_ff    <= '0;
         issuing_ff    <= 1'b0;
         pv_ff         <= 1'b0;
         hold_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         armed_ff      <= armed_in;
         running_ff    <= running_in;
         issuing_ff    <= issuing_in;
         pv_ff         <= pv_in;
         hold_ff       <= hold_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ic_ff          <= ic_in;
      pidx_ff        <= pidx_in;
      hold_idx_ff    <= hold_idx_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_expired_ff <= rsp_expired_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // count and period are only read for armed entries, which create has written
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[ic_ff];
   end

   always_ff @(posedge clock) begin
      if (per_we) begin
         per_mem[per_waddr] <= per_wdata;
      end
      per_rd_ff <= per_mem[ic_ff];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_expired     = rsp_expired_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_state_code  = rsp_code_ff;
   assign rsp_last        = rsp_last_ff;

   a_flush_emits_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |=> rsp_strobe_ff && rsp_last_ff && rsp_expired_ff)
      else $error("flush did not emit a final expiry");

   a_expiry_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_expired_ff |-> !rsp_status_ff && rsp_code_ff == CODE_STOPPED)
      else $error("expiry with bad status or state code");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_expired_ff |-> rsp_last_ff)
      else $error("command status not marked last");

   a_pop_when_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

// File: rtl/one_shot_timer_bank.sv
// one_shot_timer_bank: top level of the one-shot timer bank.
// Instantiates otb_front (decode and queue) and otb_back (execution); uses otb_pkg.
//
//   channel   | handshake                  | payload
//   request   | start in, busy out         | req_kind, req_timer_id, req_with_handler,
//             |                            | req_period_ticks, req_run_request
//   response  | rsp_strobe out, one cycle  | rsp_entry_index, rsp_expired, rsp_status,
//             |                            | rsp_state_code, rsp_last
//
// A command is executed by the back end as it is popped; its status appears the cycle after.
// A tick is popped, then walks every entry through the count/period memory read
// port in an issue stage and a process stage, then flushes the final expiry
// if any expired.
// A two-entry queue between front and back; busy is high while it is full.
// Synchronous reset clears all entries to unarmed and stopped; no clearing pass.
// The response side cannot stall: each result is valid for exactly one cycle.
`timescale 1ns / 1ps

module one_shot_timer_bank
   import otb_pkg::*;
#(
   parameter int TIMERS     = TIMERS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ID_W-1:0]     req_timer_id,
   input  logic                req_with_handler,
   input  logic [PERIOD_W-1:0] req_period_ticks,
   input  logic                req_run_request,
   output logic                rsp_strobe,
   output logic [ID_W-1:0]     rsp_entry_index,
   output logic                rsp_expired,
   output logic                rsp_status,
   output logic [CODE_W-1:0]   rsp_state_code,
   output logic                rsp_last
);

   logic           q_valid;
   queue_item_type q_item;
   logic           q_pop;

   otb_front #(
      .TIMERS (TIMERS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_timer_id     (req_timer_id),
      .req_with_handler (req_with_handler),
      .req_period_ticks (req_period_ticks),
      .req_run_request  (req_run_request),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   otb_back #(
      .TIMERS     (TIMERS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_entry_index (rsp_entry_index),
      .rsp_expired     (rsp_expired),
      .rsp_status      (rsp_status),
      .rsp_state_code  (rsp_state_code),
      .rsp_last        (rsp_last)
   );

endmodule
